// ----- rtl/cda_pkg.sv -----
package cda_pkg;

  localparam int unsigned DEF_MAX_YEAR   = 9999;
  localparam int unsigned DEF_MAX_OFFSET = 65535;

  localparam int YEAR_W = 14;
  localparam int MON_W  = 4;
  localparam int DAY_W  = 5;
  localparam int OFF_W  = 17;
  localparam int DIFF_W = 23;
  localparam int ORD_W  = 2;
  localparam int STAT_W = 2;

  localparam int REM_W   = 17;
  localparam int WY_W    = 16;
  localparam int MUL_W   = 10;
  localparam int PROD_W  = YEAR_W + MUL_W;
  localparam int QUO_W   = 8;
  localparam int RY_W    = 7;
  localparam int M400_W  = 9;
  localparam int SER_W   = 24;
  localparam int SERS_W  = SER_W + 1;

  localparam int DIV100_MUL   = 655;
  localparam int DIV100_SHIFT = 16;
  localparam int DIFF_LIMIT   = 4194303;

  localparam logic [MON_W-1:0] MONTHS   = 4'd12;
  localparam logic [MON_W-1:0] FEBRUARY = 4'd2;
  localparam logic [DAY_W-1:0] DEC_DAYS = 5'd31;
  localparam logic [M400_W-1:0] CYCLE_LAST = 9'd399;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_A = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  localparam logic [ORD_W-1:0] ORD_BEFORE = 2'd0;
  localparam logic [ORD_W-1:0] ORD_EQUAL  = 2'd1;
  localparam logic [ORD_W-1:0] ORD_AFTER  = 2'd2;

  typedef struct packed {
    logic load;
    logic sel_b;
    logic mul;
    logic fix;
    logic yrs;
    logic ser;
    logic walk;
    logic emit;
  } cda_cmd_t;

  typedef struct packed {
    logic func;
    logic valid_a;
    logic walk_done;
  } cda_sts_t;

  function automatic logic [DAY_W-1:0] month_days(input logic leap,
                                                  input logic [MON_W-1:0] month);
    logic [DAY_W-1:0] n;
    case (month)
      4'd2:    n = leap ? 5'd29 : 5'd28;
      4'd4:    n = 5'd30;
      4'd6:    n = 5'd30;
      4'd9:    n = 5'd30;
      4'd11:   n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

  function automatic logic [8:0] days_before_month(input logic [MON_W-1:0] month);
    logic [8:0] n;
    case (month)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

// ----- rtl/calendar_date_arithmetic_core.sv -----
// Gregorian date arithmetic, proleptic calendar with year 0 a leap year. With func 0 the
// core adds a signed day offset (clamped to +-MAX_OFFSET) to date A by walking one month
// per cycle once the multiply, fix, year and serial steps are done. With func 1 it returns
// the day count A minus B and their order, both dates going through the same
// divide-by-100 year unit in turn. An invalid date A skips the walk and the second
// date pass. One item is in work at a time; the next item can be taken in the cycle after
// the result is registered, and a finished result waits in the output register while
// the next item is taken. A stalled output holds a further result back.
module calendar_date_arithmetic_core
  import cda_pkg::*;
#(
  parameter int unsigned MAX_YEAR   = DEF_MAX_YEAR,
  parameter int unsigned MAX_OFFSET = DEF_MAX_OFFSET
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_func,
  input  logic [YEAR_W-1:0]        in_year_a,
  input  logic [MON_W-1:0]         in_month_a,
  input  logic [DAY_W-1:0]         in_day_a,
  input  logic [YEAR_W-1:0]        in_year_b,
  input  logic [MON_W-1:0]         in_month_b,
  input  logic [DAY_W-1:0]         in_day_b,
  input  logic signed [OFF_W-1:0]  in_offset_days,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [YEAR_W-1:0]        out_res_year,
  output logic [MON_W-1:0]         out_res_month,
  output logic [DAY_W-1:0]         out_res_day,
  output logic signed [DIFF_W-1:0] out_day_difference,
  output logic [ORD_W-1:0]         out_order,
  output logic [STAT_W-1:0]        out_status
);

  cda_cmd_t cmd;
  cda_sts_t sts;

  cda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  cda_dp #(
    .MAX_YEAR   (MAX_YEAR),
    .MAX_OFFSET (MAX_OFFSET)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_func            (in_func),
    .in_year_a          (in_year_a),
    .in_month_a         (in_month_a),
    .in_day_a           (in_day_a),
    .in_year_b          (in_year_b),
    .in_month_b         (in_month_b),
    .in_day_b           (in_day_b),
    .in_offset_days     (in_offset_days),
    .cmd                (cmd),
    .sts                (sts),
    .out_res_year       (out_res_year),
    .out_res_month      (out_res_month),
    .out_res_day        (out_res_day),
    .out_day_difference (out_day_difference),
    .out_order          (out_order),
    .out_status         (out_status)
  );

endmodule

// ----- rtl/cda_ctrl.sv -----
module cda_ctrl
  import cda_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output cda_cmd_t cmd,
  input  cda_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_FIX,
    S_YRS,
    S_SER,
    S_WALK,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   phase_b_r, phase_b_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_b_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_b_r   <= phase_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    phase_b_nxt   = phase_b_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.sel_b     = phase_b_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          phase_b_nxt = 1'b0;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_FIX;
      end
      S_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = S_YRS;
      end
      S_YRS: begin
        cmd.yrs   = 1'b1;
        state_nxt = S_SER;
      end
      S_SER: begin
        cmd.ser = 1'b1;
        if (phase_b_r || !sts.valid_a) begin
          state_nxt = S_FIN;
        end else if (sts.func) begin
          phase_b_nxt = 1'b1;
          state_nxt   = S_MUL;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- rtl/cda_dp.sv -----
module cda_dp
  import cda_pkg::*;
#(
  parameter int unsigned MAX_YEAR   = DEF_MAX_YEAR,
  parameter int unsigned MAX_OFFSET = DEF_MAX_OFFSET
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_func,
  input  logic [YEAR_W-1:0]        in_year_a,
  input  logic [MON_W-1:0]         in_month_a,
  input  logic [DAY_W-1:0]         in_day_a,
  input  logic [YEAR_W-1:0]        in_year_b,
  input  logic [MON_W-1:0]         in_month_b,
  input  logic [DAY_W-1:0]         in_day_b,
  input  logic signed [OFF_W-1:0]  in_offset_days,
  input  cda_cmd_t                 cmd,
  output cda_sts_t                 sts,
  output logic [YEAR_W-1:0]        out_res_year,
  output logic [MON_W-1:0]         out_res_month,
  output logic [DAY_W-1:0]         out_res_day,
  output logic signed [DIFF_W-1:0] out_day_difference,
  output logic [ORD_W-1:0]         out_order,
  output logic [STAT_W-1:0]        out_status
);

  localparam logic signed [SERS_W-1:0] LIM_P = SERS_W'(DIFF_LIMIT);
  localparam logic signed [SERS_W-1:0] LIM_N = -LIM_P;

  logic                     func_r;
  logic [YEAR_W-1:0]        ya_r, yb_r;
  logic [MON_W-1:0]         ma_r, mb_r;
  logic [DAY_W-1:0]         da_r, db_r;
  logic                     neg_r;
  logic [REM_W-1:0]         rem_r;
  logic [PROD_W-1:0]        prod_r;
  logic [QUO_W-1:0]         q_r;
  logic [RY_W-1:0]          r_r;
  logic [SER_W-1:0]         dby_r;
  logic                     leap_r;
  logic                     valid_r;
  logic [M400_W-1:0]        m400_r;
  logic signed [SERS_W-1:0] ser_a_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic [ORD_W-1:0]         ord_r;
  logic [WY_W-1:0]          y_r;
  logic [MON_W-1:0]         m_r;
  logic [DAY_W-1:0]         d_r;
  logic                     done_r;
  logic                     rng_r;

  logic [YEAR_W-1:0]        out_year_r;
  logic [MON_W-1:0]         out_month_r;
  logic [DAY_W-1:0]         out_day_r;
  logic signed [DIFF_W-1:0] out_diff_r;
  logic [ORD_W-1:0]         out_ord_r;
  logic [STAT_W-1:0]        out_stat_r;

  logic [REM_W-1:0]         off_mag;
  logic [REM_W-1:0]         off_sat;
  logic [MON_W-1:0]         mb_clamp;
  logic [YEAR_W-1:0]        yop;
  logic [QUO_W-1:0]         q0;
  logic [YEAR_W-1:0]        qx100;
  logic [QUO_W-1:0]         r0;
  logic [1:0]               m4;
  logic                     rnz;
  logic [M400_W-1:0]        y400;
  logic                     leap_c;
  logic [SER_W-1:0]         dby_c;
  logic                     valid_c;
  logic [MON_W-1:0]         mo;
  logic [DAY_W-1:0]         dd;
  logic signed [SERS_W-1:0] ser_c;
  logic signed [SERS_W-1:0] diff_c;
  logic signed [SERS_W-1:0] diff_sat;

  logic                     leap_w;
  logic [DAY_W-1:0]         dim_w;
  logic [DAY_W-1:0]         room;
  logic [WY_W-1:0]          y_nxt;
  logic [MON_W-1:0]         m_nxt;
  logic [DAY_W-1:0]         d_nxt;
  logic [REM_W-1:0]         rem_nxt;
  logic [M400_W-1:0]        m400_nxt;
  logic                     walk_fin;
  logic                     walk_rng;

  assign off_mag  = in_offset_days[OFF_W-1] ? $unsigned(~in_offset_days) + 1'b1
                                            : $unsigned(in_offset_days);
  assign off_sat  = (32'(off_mag) > MAX_OFFSET) ? REM_W'(MAX_OFFSET) : off_mag;
  assign mb_clamp = (in_month_b == '0)    ? MON_W'(1) :
                    (in_month_b > MONTHS) ? MONTHS : in_month_b;

  assign yop   = cmd.sel_b ? yb_r : ya_r;

  assign q0    = prod_r[DIV100_SHIFT +: QUO_W];
  assign qx100 = YEAR_W'(q0) * YEAR_W'(100);
  assign r0    = QUO_W'(yop - qx100);

  assign m4     = q_r[1:0];
  assign rnz    = (r_r != '0);
  assign y400   = M400_W'(m4) * M400_W'(100) + M400_W'(r_r);
  assign leap_c = (yop[1:0] == 2'b00) && (rnz || (m4 == 2'b00));
  assign dby_c  = SER_W'(yop) * SER_W'(365)
                + ((SER_W'(yop) + SER_W'(3)) >> 2)
                - SER_W'(q_r) - SER_W'(rnz)
                + SER_W'(q_r >> 2) + SER_W'(rnz || (m4 != 2'b00));
  assign valid_c = (32'(ya_r) <= MAX_YEAR) && (ma_r >= MON_W'(1)) && (ma_r <= MONTHS) &&
                   (da_r != '0) && (da_r <= month_days(leap_c, ma_r));

  assign mo     = cmd.sel_b ? mb_r : ma_r;
  assign dd     = cmd.sel_b ? db_r : da_r;
  assign ser_c  = SERS_W'(dby_r) + SERS_W'(days_before_month(mo))
                + SERS_W'((mo > FEBRUARY) && leap_r) + SERS_W'(dd) - SERS_W'(1);
  assign diff_c = ser_a_r - ser_c;
  assign diff_sat = (diff_c > LIM_P) ? LIM_P : (diff_c < LIM_N) ? LIM_N : diff_c;

  assign leap_w = (m400_r[1:0] == 2'b00) && (m400_r != M400_W'(100)) &&
                  (m400_r != M400_W'(200)) && (m400_r != M400_W'(300));
  assign dim_w  = month_days(leap_w, m_r);
  assign room   = dim_w - d_r;

  always_comb begin
    y_nxt    = y_r;
    m_nxt    = m_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    m400_nxt = m400_r;
    walk_fin = 1'b0;
    walk_rng = 1'b0;
    if (!neg_r) begin
      if (rem_r <= REM_W'(room)) begin
        d_nxt    = d_r + DAY_W'(rem_r);
        walk_fin = 1'b1;
      end else begin
        rem_nxt = rem_r - REM_W'(room) - 1'b1;
        d_nxt   = DAY_W'(1);
        if (m_r == MONTHS) begin
          if (y_r == WY_W'(MAX_YEAR)) begin
            d_nxt    = DEC_DAYS;
            walk_fin = 1'b1;
            walk_rng = 1'b1;
          end else begin
            y_nxt    = y_r + 1'b1;
            m_nxt    = MON_W'(1);
            m400_nxt = (m400_r == CYCLE_LAST) ? '0 : m400_r + 1'b1;
          end
        end else begin
          m_nxt = m_r + 1'b1;
        end
      end
    end else begin
      if (rem_r < REM_W'(d_r)) begin
        d_nxt    = d_r - DAY_W'(rem_r);
        walk_fin = 1'b1;
      end else begin
        rem_nxt = rem_r - REM_W'(d_r);
        if (m_r == MON_W'(1)) begin
          if (y_r == '0) begin
            d_nxt    = DAY_W'(1);
            walk_fin = 1'b1;
            walk_rng = 1'b1;
          end else begin
            y_nxt    = y_r - 1'b1;
            m_nxt    = MONTHS;
            d_nxt    = DEC_DAYS;
            m400_nxt = (m400_r == '0) ? CYCLE_LAST : m400_r - 1'b1;
          end
        end else begin
          m_nxt = m_r - 1'b1;
          d_nxt = month_days(leap_w, MON_W'(m_r - 1'b1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      ya_r   <= in_year_a;
      ma_r   <= in_month_a;
      da_r   <= in_day_a;
      yb_r   <= in_year_b;
      mb_r   <= mb_clamp;
      db_r   <= in_day_b;
      neg_r  <= in_offset_days[OFF_W-1];
      rem_r  <= off_sat;
      y_r    <= WY_W'(in_year_a);
      m_r    <= in_month_a;
      d_r    <= in_day_a;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(yop) * PROD_W'(DIV100_MUL);
    end
    if (cmd.fix) begin
      if (r0 >= QUO_W'(100)) begin
        q_r <= q0 + 1'b1;
        r_r <= RY_W'(r0 - QUO_W'(100));
      end else begin
        q_r <= q0;
        r_r <= RY_W'(r0);
      end
    end
    if (cmd.yrs) begin
      dby_r  <= dby_c;
      leap_r <= leap_c;
      if (!cmd.sel_b) begin
        m400_r  <= y400;
        valid_r <= valid_c;
      end
    end
    if (cmd.ser) begin
      if (!cmd.sel_b) begin
        ser_a_r <= ser_c;
      end else begin
        diff_r <= DIFF_W'(diff_sat);
        ord_r  <= (diff_c < 0) ? ORD_BEFORE : (diff_c == 0) ? ORD_EQUAL : ORD_AFTER;
      end
    end
    if (cmd.walk && !done_r) begin
      y_r    <= y_nxt;
      m_r    <= m_nxt;
      d_r    <= d_nxt;
      rem_r  <= rem_nxt;
      m400_r <= m400_nxt;
    end
    if (cmd.emit) begin
      out_year_r  <= func_r ? '0 : y_r[YEAR_W-1:0];
      out_month_r <= func_r ? MON_W'(1) : m_r;
      out_day_r   <= func_r ? DAY_W'(1) : d_r;
      out_diff_r  <= (func_r && valid_r) ? diff_r : '0;
      out_ord_r   <= (func_r && valid_r) ? ord_r : ORD_BEFORE;
      out_stat_r  <= !valid_r ? STAT_BAD_A :
                     (!func_r && rng_r) ? STAT_RANGE : STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
      rng_r  <= 1'b0;
    end else if (cmd.load) begin
      done_r <= 1'b0;
      rng_r  <= 1'b0;
    end else if (cmd.walk && !done_r) begin
      done_r <= walk_fin;
      rng_r  <= walk_rng;
    end
  end

  assign sts.func      = func_r;
  assign sts.valid_a   = valid_r;
  assign sts.walk_done = done_r;

  assign out_res_year       = out_year_r;
  assign out_res_month      = out_month_r;
  assign out_res_day        = out_day_r;
  assign out_day_difference = out_diff_r;
  assign out_order          = out_ord_r;
  assign out_status         = out_stat_r;

`ifndef SYNTH
  a_fix_rem: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fix |=> (r_r < RY_W'(100)))
    else $error("year remainder not reduced below one hundred");

  a_walk_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.walk && !done_r) |=> (rem_r <= $past(rem_r)))
    else $error("day count grew during month walk");

  a_walk_date: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && !rng_r) |-> ((m_r >= MON_W'(1)) && (m_r <= MONTHS) &&
                            (d_r != '0) && (d_r <= dim_w)))
    else $error("month walk ended on an impossible date");

  a_range_date: assert property (@(posedge clk) disable iff (!rst_n)
    rng_r |-> (((m_r == MONTHS) && (d_r == DEC_DAYS)) ||
               ((y_r == '0) && (m_r == MON_W'(1)) && (d_r == DAY_W'(1)))))
    else $error("range error without clamped date");
`endif

endmodule

// ----- verif/calendar_date_arithmetic_checker.sv -----
package cda_tb_pkg;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_DIFF = 1'b1;

endpackage

module calendar_date_arithmetic_checker
  import cda_pkg::*;
  import cda_tb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     in_func,
  input  logic [YEAR_W-1:0]        in_year_a,
  input  logic [MON_W-1:0]         in_month_a,
  input  logic [DAY_W-1:0]         in_day_a,
  input  logic [YEAR_W-1:0]        in_year_b,
  input  logic [MON_W-1:0]         in_month_b,
  input  logic [DAY_W-1:0]         in_day_b,
  input  logic signed [OFF_W-1:0]  in_offset_days,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [YEAR_W-1:0]        out_res_year,
  input  logic [MON_W-1:0]         out_res_month,
  input  logic [DAY_W-1:0]         out_res_day,
  input  logic signed [DIFF_W-1:0] out_day_difference,
  input  logic [ORD_W-1:0]         out_order,
  input  logic [STAT_W-1:0]        out_status,
  output int                       mismatches,
  output int                       outstanding,
  output int                       adds_seen,
  output int                       diffs_seen,
  output int                       bad_dates,
  output int                       range_hits
);

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
    logic [DIFF_W-1:0] diff;
    logic [ORD_W-1:0]  ord;
    logic [STAT_W-1:0] stat;
  } date_result_t;

  date_result_t due_q[$];
  int fail_cnt = 0;
  int add_cnt = 0;
  int diff_cnt = 0;
  int bad_cnt = 0;
  int range_cnt = 0;

  function automatic bit leap_year(input longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint month_length(input longint y, input longint m);
    case (m)
      longint'(FEBRUARY): return leap_year(y) ? 29 : 28;
      4, 6, 9, 11:        return 30;
      default:            return 31;
    endcase
  endfunction

  function automatic longint year_start(input longint y);
    return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
  endfunction

  function automatic longint day_number(input longint y, input longint m, input longint d);
    longint s;
    s = year_start(y);
    for (longint k = 1; k < m; k++) s += month_length(y, k);
    return s + d - 1;
  endfunction

  function automatic void calendar_of(input longint s, output longint y, output longint m,
                                      output longint d);
    longint rest;
    y = (s * 400) / 146097;
    while (y > 0 && year_start(y) > s) y--;
    while (year_start(y + 1) <= s) y++;
    rest = s - year_start(y);
    m = 1;
    while (m < longint'(MONTHS) && rest >= month_length(y, m)) begin
      rest -= month_length(y, m);
      m++;
    end
    d = rest + 1;
  endfunction

  function automatic date_result_t compute_result(
    input logic op,
    input logic [YEAR_W-1:0] ya, input logic [MON_W-1:0] ma, input logic [DAY_W-1:0] da,
    input logic [YEAR_W-1:0] yb, input logic [MON_W-1:0] mb, input logic [DAY_W-1:0] db,
    input logic signed [OFF_W-1:0] shift);
    date_result_t r;
    longint y, m, d, mb_l, s, delta, span;
    bit a_ok;
    y = longint'(ya);
    m = longint'(ma);
    d = longint'(da);
    r = '{year: '0, month: MON_W'(1), day: DAY_W'(1), diff: '0, ord: ORD_BEFORE,
          stat: STAT_OK};
    a_ok = y <= longint'(DEF_MAX_YEAR) && m >= 1 && m <= longint'(MONTHS) && d >= 1 &&
           d <= month_length(y, m);
    if (!a_ok) begin
      r.stat = STAT_BAD_A;
      if (op == OP_ADD) begin
        r.year  = ya;
        r.month = ma;
        r.day   = da;
      end
    end else if (op == OP_ADD) begin
      delta = longint'(shift);
      if (delta > longint'(DEF_MAX_OFFSET)) delta = longint'(DEF_MAX_OFFSET);
      if (delta < -longint'(DEF_MAX_OFFSET)) delta = -longint'(DEF_MAX_OFFSET);
      s = day_number(y, m, d) + delta;
      if (s < 0) begin
        r.stat = STAT_RANGE;
      end else if (s >= year_start(longint'(DEF_MAX_YEAR) + 1)) begin
        r.stat  = STAT_RANGE;
        r.year  = YEAR_W'(DEF_MAX_YEAR);
        r.month = MONTHS;
        r.day   = DEC_DAYS;
      end else begin
        calendar_of(s, y, m, d);
        r.year  = y[YEAR_W-1:0];
        r.month = m[MON_W-1:0];
        r.day   = d[DAY_W-1:0];
      end
    end else begin
      mb_l = longint'(mb);
      if (mb_l < 1) mb_l = 1;
      if (mb_l > longint'(MONTHS)) mb_l = longint'(MONTHS);
      span = day_number(y, m, d) - day_number(longint'(yb), mb_l, longint'(db));
      r.ord = (span < 0) ? ORD_BEFORE : ((span == 0) ? ORD_EQUAL : ORD_AFTER);
      if (span > longint'(DIFF_LIMIT)) span = longint'(DIFF_LIMIT);
      if (span < -longint'(DIFF_LIMIT)) span = -longint'(DIFF_LIMIT);
      r.diff = span[DIFF_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    date_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: result with nothing expected: y=%0d m=%0d d=%0d diff=%0d ord=%0d st=%0d",
                     $time, out_res_year, out_res_month, out_res_day, out_day_difference,
                     out_order, out_status);
        end else begin
          want = due_q.pop_front();
          if (want.stat == STAT_BAD_A) bad_cnt++;
          if (want.stat == STAT_RANGE) range_cnt++;
          if (out_res_year !== want.year || out_res_month !== want.month ||
              out_res_day !== want.day || out_day_difference !== want.diff ||
              out_order !== want.ord || out_status !== want.stat) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display({"%0t: mismatch: expected y=%0d m=%0d d=%0d diff=%0d ord=%0d st=%0d, ",
                        "got y=%0d m=%0d d=%0d diff=%0d ord=%0d st=%0d"},
                       $time, want.year, want.month, want.day, $signed(want.diff), want.ord,
                       want.stat, out_res_year, out_res_month, out_res_day,
                       out_day_difference, out_order, out_status);
          end
        end
      end
      if (in_valid && !in_stall) begin
        due_q.push_back(compute_result(in_func, in_year_a, in_month_a, in_day_a, in_year_b,
                                       in_month_b, in_day_b, in_offset_days));
        if (in_func == OP_ADD) add_cnt++;
        else diff_cnt++;
      end
    end
    mismatches  <= fail_cnt;
    outstanding <= due_q.size();
    adds_seen   <= add_cnt;
    diffs_seen  <= diff_cnt;
    bad_dates   <= bad_cnt;
    range_hits  <= range_cnt;
  end

endmodule

// ----- verif/calendar_date_arithmetic_core_tb.sv -----
module calendar_date_arithmetic_core_tb;
  import cda_pkg::*;
  import cda_tb_pkg::*;

  localparam int unsigned STALL_LIMIT = 20000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_func = OP_ADD;
  logic [YEAR_W-1:0]        in_year_a = '0;
  logic [MON_W-1:0]         in_month_a = '0;
  logic [DAY_W-1:0]         in_day_a = '0;
  logic [YEAR_W-1:0]        in_year_b = '0;
  logic [MON_W-1:0]         in_month_b = '0;
  logic [DAY_W-1:0]         in_day_b = '0;
  logic signed [OFF_W-1:0]  in_offset_days = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [YEAR_W-1:0]        out_res_year;
  logic [MON_W-1:0]         out_res_month;
  logic [DAY_W-1:0]         out_res_day;
  logic signed [DIFF_W-1:0] out_day_difference;
  logic [ORD_W-1:0]         out_order;
  logic [STAT_W-1:0]        out_status;

  int mismatches, outstanding, adds_seen, diffs_seen, bad_dates, range_hits;
  bit calm = 1'b0;
  int unsigned idle_run = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  calendar_date_arithmetic_core dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_func, .in_year_a, .in_month_a, .in_day_a,
    .in_year_b, .in_month_b, .in_day_b, .in_offset_days, .out_valid, .out_stall,
    .out_res_year, .out_res_month, .out_res_day, .out_day_difference, .out_order,
    .out_status
  );

  calendar_date_arithmetic_checker date_check (
    .clk, .rst_n, .in_valid, .in_stall, .in_func, .in_year_a, .in_month_a, .in_day_a,
    .in_year_b, .in_month_b, .in_day_b, .in_offset_days, .out_valid, .out_stall,
    .out_res_year, .out_res_month, .out_res_day, .out_day_difference, .out_order,
    .out_status, .mismatches, .outstanding, .adds_seen, .diffs_seen, .bad_dates,
    .range_hits
  );

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_run <= 0;
    end else if (idle_run == STALL_LIMIT) begin
      $display("calendar_date_arithmetic_core_tb failed");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic int pick_year();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 3);
      1:       return $urandom_range(9996, 9999);
      2:       return 100 * $urandom_range(0, 99);
      default: return $urandom_range(0, 9999);
    endcase
  endfunction

  task automatic send(input logic op, input int ya, input int ma, input int da,
                      input int yb, input int mb, input int db, input int off);
    in_valid       <= 1'b1;
    in_func        <= op;
    in_year_a      <= YEAR_W'(ya);
    in_month_a     <= MON_W'(ma);
    in_day_a       <= DAY_W'(da);
    in_year_b      <= YEAR_W'(yb);
    in_month_b     <= MON_W'(mb);
    in_day_b       <= DAY_W'(db);
    in_offset_days <= OFF_W'(off);
    do @(posedge clk); while (in_stall);
    if (!calm && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send(OP_ADD, 2000, 2, 28, 0, 1, 1, 1);
    send(OP_ADD, 1900, 2, 28, 0, 1, 1, 1);
    send(OP_ADD, 0, 1, 1, 0, 1, 1, -1);
    send(OP_ADD, 9999, 12, 31, 0, 1, 1, 1);
    send(OP_ADD, 2024, 3, 1, 0, 1, 1, -65536);
    send(OP_ADD, 2024, 3, 1, 0, 1, 1, 65535);
    send(OP_ADD, 0, 1, 1, 0, 1, 1, 65535);
    send(OP_ADD, 9999, 12, 31, 0, 1, 1, -65535);
    send(OP_ADD, 2400, 2, 29, 0, 1, 1, 0);
    send(OP_ADD, 2023, 5, 0, 0, 1, 1, 10);
    send(OP_ADD, 2023, 0, 10, 0, 1, 1, 5);
    send(OP_ADD, 2023, 13, 10, 0, 1, 1, 5);
    send(OP_ADD, 16383, 15, 31, 16383, 15, 31, -1);
    send(OP_ADD, 2023, 4, 31, 0, 1, 1, 3);
    send(OP_ADD, 2023, 2, 29, 0, 1, 1, 3);
    send(OP_ADD, 2024, 2, 30, 0, 1, 1, 3);
    send(OP_DIFF, 2024, 1, 15, 2024, 1, 15, 0);
    send(OP_DIFF, 2024, 1, 15, 2024, 3, 1, 0);
    send(OP_DIFF, 2024, 6, 1, 2024, 0, 1, 0);
    send(OP_DIFF, 2024, 6, 1, 2024, 15, 31, 0);
    send(OP_DIFF, 2024, 3, 1, 2024, 3, 0, 0);
    send(OP_DIFF, 2024, 3, 1, 2023, 2, 31, 0);
    send(OP_DIFF, 0, 1, 1, 16383, 15, 31, 0);
    send(OP_DIFF, 9999, 12, 31, 0, 1, 0, 0);
    send(OP_DIFF, 10000, 11, 31, 2023, 1, 1, 0);
    drain();

    for (int i = 0; i < 245; i++) begin
      int ya, ma, da, yb, mb, db, off;
      calm = (i >= 205);
      if (i == 120) drain();
      if ($urandom_range(0, 9) == 0) begin
        ya  = $urandom_range(0, 16383);
        ma  = $urandom_range(0, 15);
        da  = $urandom_range(0, 31);
        yb  = $urandom_range(0, 16383);
        mb  = $urandom_range(0, 15);
        db  = $urandom_range(0, 31);
        off = int'($urandom_range(0, 131071)) - 65536;
      end else begin
        ya = pick_year();
        ma = $urandom_range(1, 12);
        da = ($urandom_range(0, 2) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28);
        if ($urandom_range(0, 4) == 0) begin
          yb = $urandom_range(0, 16383);
          mb = $urandom_range(0, 15);
          db = $urandom_range(0, 31);
        end else begin
          yb = $urandom_range(0, 1) ? pick_year() : ya;
          mb = $urandom_range(1, 12);
          db = $urandom_range(1, 28);
        end
        case ($urandom_range(0, 9))
          0:       off = int'($urandom_range(0, 131071)) - 65536;
          1, 2:    off = int'($urandom_range(0, 10000)) - 5000;
          default: off = int'($urandom_range(0, 800)) - 400;
        endcase
      end
      send(($urandom_range(0, 1) == 0) ? OP_ADD : OP_DIFF, ya, ma, da, yb, mb, db, off);
    end

    drain();
    repeat (30) @(posedge clk);

    $display("Ran %0d add and %0d difference items: %0d rejected for a bad date A,",
             adds_seen, diffs_seen, bad_dates);
    $display("%0d pinned at the year range limits, under random stalls on both channels.",
             range_hits);
    if (mismatches == 0) begin
      $display("calendar_date_arithmetic_core_tb passed");
    end else begin
      $display("calendar_date_arithmetic_core_tb failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/cda_pkg.sv
rtl/cda_ctrl.sv
rtl/cda_dp.sv
rtl/calendar_date_arithmetic_core.sv
verif/calendar_date_arithmetic_checker.sv
verif/calendar_date_arithmetic_core_tb.sv
